// ===== src/sle_pkg.sv =====
package sle_pkg;

    // input modes
    localparam logic [1:0] MODE_KEY   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // result outcome codes
    localparam logic [2:0] OUT_IGNORED   = 3'd0;
    localparam logic [2:0] OUT_EDITED    = 3'd1;
    localparam logic [2:0] OUT_COMMITTED = 3'd2;
    localparam logic [2:0] OUT_ABORTED   = 3'd3;
    localparam logic [2:0] OUT_FULL      = 3'd4;
    localparam logic [2:0] OUT_DONE      = 3'd5;

    // key bytes
    localparam logic [7:0] KEY_NEWLINE   = 8'd10;
    localparam logic [7:0] KEY_BACKSPACE = 8'd8;
    localparam logic [7:0] KEY_ESC       = 8'd27;
    localparam logic [7:0] KEY_NUL       = 8'd0;
    localparam logic [7:0] KEY_BRACKET   = 8'h5B;
    localparam logic [7:0] KEY_ARROW_L   = 8'h44;
    localparam logic [7:0] KEY_ARROW_R   = 8'h43;
    localparam logic [7:0] KEY_SPACE     = 8'h20;
    localparam logic [7:0] KEY_TILDE     = 8'h7E;

    // narrowest view the editor works with
    localparam logic [7:0] MIN_VIEW = 8'd3;

    // decoded operation of one word
    typedef enum logic [3:0] {
        OP_NONE,
        OP_COMMIT,
        OP_ABORT,
        OP_INSERT,
        OP_DELETE,
        OP_LEFT,
        OP_RIGHT,
        OP_CLEAR,
        OP_LOAD,
        OP_READ
    } op_t;

    // key sequence and mode to operation
    function automatic op_t decode_key(input logic [1:0] mode, input logic [7:0] k0,
                                       input logic [7:0] k1, input logic [7:0] k2);
        op_t op;
        op = OP_NONE;
        unique case (mode)
            MODE_CLEAR: op = OP_CLEAR;
            MODE_LOAD:  op = OP_LOAD;
            MODE_READ:  op = OP_READ;
            default:
            begin
                priority if (k0 == KEY_NEWLINE)
                    op = OP_COMMIT;
                else if (k0 == KEY_BACKSPACE)
                    op = OP_DELETE;
                else if (k0 == KEY_ESC)
                begin
                    priority if (k1 == KEY_NUL)
                        op = OP_ABORT;
                    else if (k1 == KEY_BRACKET && k2 == KEY_ARROW_L)
                        op = OP_LEFT;
                    else if (k1 == KEY_BRACKET && k2 == KEY_ARROW_R)
                        op = OP_RIGHT;
                    else
                        op = OP_NONE;
                end
                else if (k0 >= KEY_SPACE && k0 <= KEY_TILDE)
                    op = OP_INSERT;
                else
                    op = OP_NONE;
            end
        endcase
        return op;
    endfunction

    // floor(v / 3) for an 8-bit value by reciprocal multiply
    function automatic logic [7:0] div3(input logic [7:0] v);
        logic [15:0] p;
        p = 16'(v) * 16'd171;
        return {1'b0, p[15:9]};
    endfunction

endpackage

// ===== src/sle_key_if.sv =====
interface sle_key_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] key_first;
    logic [7:0] key_second;
    logic [7:0] key_third;
    logic [7:0] load_byte;
    logic [7:0] read_index;

    modport source
    (
        output valid, mode, key_first, key_second, key_third, load_byte, read_index,
        input  ready
    );

    modport sink
    (
        input  valid, mode, key_first, key_second, key_third, load_byte, read_index,
        output ready
    );
endinterface

// ===== src/sle_result_if.sv =====
interface sle_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] outcome;
    logic [7:0] cursor_pos;
    logic [8:0] view_start;
    logic [8:0] text_length;
    logic [7:0] read_char;

    modport source
    (
        output valid, outcome, cursor_pos, view_start, text_length, read_char,
        input  ready
    );

    modport sink
    (
        input  valid, outcome, cursor_pos, view_start, text_length, read_char,
        output ready
    );
endinterface

// ===== src/sle_ram.sv =====
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/scrolling_line_editor_top.sv =====
// Scrolling line editor.
// key_chan carries one word per key event or command (mode, up to three key
// bytes, a load byte, a read index); result_chan returns exactly one result
// word per accepted word. view_width is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle; the block does not enforce it.
// Commit, abort, ignored keys, arrows, clear, load and read pass from accept
// through the prepare, update and finish states to result valid, as do a
// dropped insert and a backspace at the start of the view. An insert and a
// backspace also pass through the shift state, and an insert then through
// the put state that writes the new byte; the store is shifted one byte per
// cycle through the single write port of the character RAM.
// key_chan.ready is high only while no word is in progress, so a new word
// is not taken before the last one has handed its result to the output register.
// A finished result sits in an output register; while the receiver stalls,
// the next word is still accepted and processed up to its result, which then
// waits for the register to empty.
// Reset clears the cursor, view, fill count, view_width (to 32) and the
// output valid; the character store is not cleared and needs no sweep.
module scrolling_line_editor_top #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    sle_key_if.sink             key_chan,
    sle_result_if.source        result_chan
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    // view plus an 8-bit cursor, never narrower than 10 bits
    localparam int PW = (CW > 9) ? CW + 1 : 10;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] S_ZERO = '0;
    localparam logic signed [SW-1:0] S_ONE  = SW'(1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PREP   = 6'b000010,
        S_CALC   = 6'b000100,
        S_SHIFT  = 6'b001000,
        S_PUT    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    sle_pkg::op_t   op_reg, op_next;
    logic [7:0]     char_reg, char_next;
    logic [7:0]     load_reg, load_next;
    logic [7:0]     ridx_reg, ridx_next;
    logic [7:0]     vw_reg, vw_next;

    logic [7:0]     cursor_reg, cursor_next;
    logic [CW-1:0]  view_reg, view_next;
    logic [CW-1:0]  fill_reg, fill_next;

    logic [7:0]     w_reg, w_next;
    logic [7:0]     w3_reg, w3_next;
    logic [7:0]     w2_reg, w2_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic signed [SW-1:0] right_reg, right_next;

    logic [2:0]     outcome_reg, outcome_next;
    logic [7:0]     rc_reg, rc_next;

    logic [AW-1:0]  sh_idx_reg, sh_idx_next;
    logic [CW-1:0]  sh_cnt_reg, sh_cnt_next;
    logic           sh_up_reg, sh_up_next;
    logic           pend_reg, pend_next;
    logic [AW-1:0]  pend_addr_reg, pend_addr_next;
    logic [AW-1:0]  put_addr_reg, put_addr_next;

    logic           out_valid_reg, out_valid_next;
    logic [2:0]     out_outcome_reg, out_outcome_next;
    logic [7:0]     out_cursor_reg, out_cursor_next;
    logic [8:0]     out_view_reg, out_view_next;
    logic [8:0]     out_len_reg, out_len_next;
    logic [7:0]     out_rc_reg, out_rc_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    // signed working copies for the cursor and view rules
    logic signed [SW-1:0] s_cur, s_view, s_fill, s_w, s_w3, s_w2;
    logic signed [SW-1:0] s_filln, room1, room2, target_a, target, view_s;
    logic           at_end;
    logic [CW-1:0]  ed_pos;
    logic           full;

    // clamp a signed view value at zero
    function automatic logic [CW-1:0] clamp_view(input logic signed [SW-1:0] v);
        return (v < S_ZERO) ? '0 : v[CW-1:0];
    endfunction

    sle_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake and output drive
    assign key_chan.ready          = (state_reg == S_IDLE);
    assign result_chan.valid       = out_valid_reg;
    assign result_chan.outcome     = out_outcome_reg;
    assign result_chan.cursor_pos  = out_cursor_reg;
    assign result_chan.view_start  = out_view_reg;
    assign result_chan.text_length = out_len_reg;
    assign result_chan.read_char   = out_rc_reg;

    // sequencer and datapath
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        char_next        = char_reg;
        load_next        = load_reg;
        ridx_next        = ridx_reg;
        vw_next          = cfg_wr_en ? cfg_wr_data : vw_reg;
        cursor_next      = cursor_reg;
        view_next        = view_reg;
        fill_next        = fill_reg;
        w_next           = w_reg;
        w3_next          = w3_reg;
        w2_next          = w2_reg;
        pos_next         = pos_reg;
        right_next       = right_reg;
        outcome_next     = outcome_reg;
        rc_next          = rc_reg;
        sh_idx_next      = sh_idx_reg;
        sh_cnt_next      = sh_cnt_reg;
        sh_up_next       = sh_up_reg;
        pend_next        = 1'b0;
        pend_addr_next   = pend_addr_reg;
        put_addr_next    = put_addr_reg;
        out_outcome_next = out_outcome_reg;
        out_cursor_next  = out_cursor_reg;
        out_view_next    = out_view_reg;
        out_len_next     = out_len_reg;
        out_rc_next      = out_rc_reg;
        out_valid_next   = (out_valid_reg && !result_chan.ready);

        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = (state_reg == S_PREP) ? AW'(ridx_reg) : sh_idx_reg;

        s_cur    = SW'(cursor_reg);
        s_view   = SW'(view_reg);
        s_fill   = SW'(fill_reg);
        s_w      = SW'(w_reg);
        s_w3     = SW'(w3_reg);
        s_w2     = SW'(w2_reg);
        s_filln  = s_fill + S_ONE;
        room1    = s_w - s_filln + S_ONE;
        room2    = s_w3 + s_w3 - s_cur + S_ONE;
        target_a = S_ZERO;
        target   = S_ZERO;
        view_s   = S_ZERO;
        at_end   = (pos_reg >= PW'(fill_reg));
        ed_pos   = at_end ? fill_reg : pos_reg[CW-1:0];
        full     = (32'(fill_reg) >= BUFFER_DEPTH);

        unique case (state_reg)
            S_IDLE:
            begin
                if (key_chan.valid)
                begin
                    op_next    = sle_pkg::decode_key(key_chan.mode, key_chan.key_first,
                                                     key_chan.key_second, key_chan.key_third);
                    char_next  = key_chan.key_first;
                    load_next  = key_chan.load_byte;
                    ridx_next  = key_chan.read_index;
                    state_next = S_PREP;
                end
            end

            // effective width and the derived view thresholds
            S_PREP:
            begin
                w_next     = (vw_reg < sle_pkg::MIN_VIEW) ? sle_pkg::MIN_VIEW : vw_reg;
                w3_next    = sle_pkg::div3(w_next);
                w2_next    = {1'b0, w_next[7:1]};
                pos_next   = PW'(view_reg) + PW'(cursor_reg);
                right_next = SW'(fill_reg) - SW'(view_reg) - SW'(w_next);
                state_next = S_CALC;
            end

            // cursor and view rules, shift setup
            S_CALC:
            begin
                rc_next      = 8'd0;
                outcome_next = sle_pkg::OUT_EDITED;
                state_next   = S_FINISH;
                unique case (op_reg)
                    sle_pkg::OP_NONE:   outcome_next = sle_pkg::OUT_IGNORED;
                    sle_pkg::OP_COMMIT: outcome_next = sle_pkg::OUT_COMMITTED;
                    sle_pkg::OP_ABORT:  outcome_next = sle_pkg::OUT_ABORTED;
                    sle_pkg::OP_CLEAR:
                    begin
                        outcome_next = sle_pkg::OUT_DONE;
                        fill_next    = '0;
                        cursor_next  = 8'd0;
                        view_next    = '0;
                    end
                    sle_pkg::OP_LOAD:
                    begin
                        if (full)
                        begin
                            outcome_next = sle_pkg::OUT_FULL;
                        end
                        else
                        begin
                            outcome_next = sle_pkg::OUT_DONE;
                            ram_we       = 1'b1;
                            ram_waddr    = AW'(fill_reg);
                            ram_wdata    = load_reg;
                            fill_next    = fill_reg + CW'(1);
                            cursor_next  = 8'd0;
                            view_next    = '0;
                        end
                    end
                    sle_pkg::OP_READ:
                    begin
                        outcome_next = sle_pkg::OUT_DONE;
                        rc_next      = (CW'(ridx_reg) < fill_reg || CW < 8 &&
                                        ridx_reg < 8'(fill_reg)) &&
                                       (32'(ridx_reg) < 32'(fill_reg)) ? ram_rdata : 8'd0;
                    end
                    sle_pkg::OP_INSERT:
                    begin
                        if (full)
                        begin
                            outcome_next = sle_pkg::OUT_FULL;
                        end
                        else
                        begin
                            fill_next     = fill_reg + CW'(1);
                            put_addr_next = AW'(ed_pos);
                            sh_up_next    = 1'b1;
                            sh_idx_next   = AW'(fill_reg - CW'(1));
                            sh_cnt_next   = fill_reg - ed_pos;
                            state_next    = S_SHIFT;
                            if (at_end)
                            begin
                                target      = (s_cur + S_ONE < s_w - S_ONE) ?
                                              s_cur + S_ONE : s_w - S_ONE;
                                cursor_next = target[7:0];
                                view_next   = clamp_view(s_filln - target);
                            end
                            else if (room1 > S_ZERO || room2 > S_ZERO)
                            begin
                                cursor_next = (cursor_reg == 8'd255) ? 8'd255
                                                                     : cursor_reg + 8'd1;
                            end
                            else
                            begin
                                view_next = view_reg + CW'(1);
                            end
                        end
                    end
                    sle_pkg::OP_DELETE:
                    begin
                        if (cursor_reg != 8'd0 && fill_reg != '0)
                        begin
                            fill_next   = fill_reg - CW'(1);
                            sh_up_next  = 1'b0;
                            sh_idx_next = AW'(ed_pos);
                            sh_cnt_next = fill_reg - ed_pos;
                            state_next  = S_SHIFT;
                            priority if (s_cur > s_w3 && right_reg > S_ZERO)
                                cursor_next = cursor_reg - 8'd1;
                            else if (view_reg != '0)
                                view_next = view_reg - CW'(1);
                            else
                                cursor_next = cursor_reg - 8'd1;
                        end
                    end
                    sle_pkg::OP_LEFT:
                    begin
                        priority if (s_cur <= s_w3 && view_reg != '0)
                        begin
                            target_a    = s_view + s_cur - S_ONE;
                            target      = (s_w2 < target_a) ? s_w2 : target_a;
                            view_s      = s_view - (target - s_cur + S_ONE);
                            view_next   = clamp_view(view_s);
                            cursor_next = target[7:0];
                        end
                        else if (pos_reg == PW'(fill_reg) && view_reg != '0)
                            view_next = view_reg - CW'(1);
                        else if (cursor_reg != 8'd0)
                            cursor_next = cursor_reg - 8'd1;
                        else
                            cursor_next = cursor_reg;
                    end
                    sle_pkg::OP_RIGHT:
                    begin
                        priority if (at_end)
                            cursor_next = cursor_reg;
                        else if (s_cur > s_w3 + s_w3 && right_reg > S_ZERO)
                        begin
                            target_a    = s_cur - right_reg + S_ONE;
                            target      = (target_a < s_w2) ? s_w2 : target_a;
                            view_s      = s_view + s_cur - target + S_ONE;
                            view_next   = clamp_view(view_s);
                            cursor_next = target[7:0];
                        end
                        else if (pos_reg == PW'(fill_reg) - PW'(1) &&
                                 cursor_reg == w_reg - 8'd1)
                            view_next = view_reg + CW'(1);
                        else if (cursor_reg != 8'd255)
                            cursor_next = cursor_reg + 8'd1;
                        else
                            cursor_next = cursor_reg;
                    end
                    default: outcome_next = sle_pkg::OUT_IGNORED;
                endcase
            end

            // move one byte per cycle: read ahead, write the byte read last cycle
            S_SHIFT:
            begin
                if (sh_cnt_reg != '0)
                begin
                    sh_idx_next    = sh_up_reg ? sh_idx_reg - AW'(1) : sh_idx_reg + AW'(1);
                    sh_cnt_next    = sh_cnt_reg - CW'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = sh_up_reg ? sh_idx_reg + AW'(1) : sh_idx_reg - AW'(1);
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (sh_cnt_reg == '0 && !pend_reg)
                begin
                    state_next = sh_up_reg ? S_PUT : S_FINISH;
                end
            end

            // drop the new byte into the gap
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = put_addr_reg;
                ram_wdata  = char_reg;
                state_next = S_FINISH;
            end

            // hand the result to the output register once it is free
            S_FINISH:
            begin
                if (!out_valid_reg || result_chan.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_outcome_next = outcome_reg;
                    out_cursor_next  = cursor_reg;
                    out_view_next    = 9'(view_reg);
                    out_len_next     = 9'(fill_reg);
                    out_rc_next      = rc_reg;
                    state_next       = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vw_reg        <= 8'd32;
            cursor_reg    <= 8'd0;
            view_reg      <= '0;
            fill_reg      <= '0;
            sh_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vw_reg        <= vw_next;
            cursor_reg    <= cursor_next;
            view_reg      <= view_next;
            fill_reg      <= fill_next;
            sh_cnt_reg    <= sh_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        char_reg        <= char_next;
        load_reg        <= load_next;
        ridx_reg        <= ridx_next;
        w_reg           <= w_next;
        w3_reg          <= w3_next;
        w2_reg          <= w2_next;
        pos_reg         <= pos_next;
        right_reg       <= right_next;
        outcome_reg     <= outcome_next;
        rc_reg          <= rc_next;
        sh_idx_reg      <= sh_idx_next;
        sh_up_reg       <= sh_up_next;
        pend_addr_reg   <= pend_addr_next;
        put_addr_reg    <= put_addr_next;
        out_outcome_reg <= out_outcome_next;
        out_cursor_reg  <= out_cursor_next;
        out_view_reg    <= out_view_next;
        out_len_reg     <= out_len_next;
        out_rc_reg      <= out_rc_next;
    end

    // the view never starts past the end of the text
    assert property (@(posedge clk) disable iff (!rst_n) view_reg <= fill_reg)
        else $error("view start beyond text length");

    // an accepted word always goes to the prepare step next
    assert property (@(posedge clk) disable iff (!rst_n)
                     key_chan.valid && key_chan.ready |=> state_reg == S_PREP)
        else $error("accepted word not taken into prepare step");

    // the fill count only moves when leaving the update step
    assert property (@(posedge clk) disable iff (!rst_n)
                     state_reg != S_CALC |=> $stable(fill_reg))
        else $error("fill count changed outside the update step");

    // the fill count never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n) 32'(fill_reg) <= BUFFER_DEPTH)
        else $error("fill count beyond store depth");

endmodule
